// ----- design/usf_pkg.sv -----
// ----------------------------------------------------------------------------
// usf_pkg
// Shared constants and the controller/datapath command and status types of
// the universal sink finder.
// ----------------------------------------------------------------------------
package usf_pkg;

  // Width of one matrix row, and so the largest matrix the block can hold.
  localparam int ROW_W          = 32;
  // Width of the people count register.
  localparam int COUNT_W        = 6;
  // Width of the reported person index.
  localparam int IDX_W          = 5;
  // Default for the storage depth parameter.
  localparam int DEF_MAX_PEOPLE = 32;
  // People count after reset.
  localparam logic [COUNT_W-1:0] PEOPLE_RESET = 6'd32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // store the accepted row and update the candidate
    logic walk_start;  // the last row is in: arm the verification walk
    logic walk_step;   // advance the verification walk by one row
    logic publish;     // load the result register
  } usf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_row;    // the row now offered completes the matrix
    logic walk_end;    // the final row of the walk is being checked
    logic out_free;    // the result register can take a new result
  } usf_sts_t;

endpackage

// ----- design/usf_ctrl.sv -----
// ----------------------------------------------------------------------------
// usf_ctrl
// Controller of the universal sink finder: sequences row loading, the
// verification walk and the hand-over of the result.
// ----------------------------------------------------------------------------
module usf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output usf_pkg::usf_cmd_t cmd,
  input  usf_pkg::usf_sts_t sts
);
  import usf_pkg::*;

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Rows are taken only while loading.
  assign in_ready = (state == S_LOAD);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.last_row) begin
            cmd.walk_start = 1'b1;
            state_next     = S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_end) begin
          if (sts.out_free) begin
            cmd.publish = 1'b1;
            state_next  = S_LOAD;
          end else begin
            state_next  = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/usf_datapath.sv -----
// ----------------------------------------------------------------------------
// usf_datapath
// Datapath of the universal sink finder: row memory, elimination candidate,
// verification walk and result register.
// ----------------------------------------------------------------------------
module usf_datapath #(
  parameter int MAX_PEOPLE = usf_pkg::DEF_MAX_PEOPLE
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [usf_pkg::COUNT_W-1:0] cfg_wdata,
  input  logic [usf_pkg::ROW_W-1:0]   row_bits,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        found,
  output logic [usf_pkg::IDX_W-1:0]   celebrity_index,
  input  usf_pkg::usf_cmd_t           cmd,
  output usf_pkg::usf_sts_t           sts
);
  import usf_pkg::*;

  localparam int PEOPLE_CAP = (MAX_PEOPLE < ROW_W) ? MAX_PEOPLE : ROW_W;
  localparam int ADDR_W     = $clog2(PEOPLE_CAP);
  localparam int CNT_W      = ADDR_W + 1;
  localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(PEOPLE_CAP);

  logic [COUNT_W-1:0] people_count;
  logic [COUNT_W-1:0] n_use;
  logic [CNT_W-1:0]   rows_loaded;
  logic [ADDR_W-1:0]  candidate;
  logic [ROW_W-1:0]   cand_row;
  logic [ROW_W-1:0]   rows_mem [PEOPLE_CAP];
  logic [CNT_W-1:0]   walk_addr;
  logic [ADDR_W-1:0]  rd_idx;
  logic [ROW_W-1:0]   rd_data;
  logic               rd_pend;
  logic               ok;
  logic               ok_now;
  logic               issue;
  logic               diag_ok;
  logic               found_now;
  logic [ROW_W:0]     span_mask;

  // People count in use, saturated to the range the memory holds.
  always_comb begin
    if (people_count == '0) begin
      n_use = COUNT_W'(1);
    end else if (people_count > CAP_COUNT) begin
      n_use = CAP_COUNT;
    end else begin
      n_use = people_count;
    end
  end

  // Bits 0..n-1 of a row are the ones that count.
  assign span_mask = ({{ROW_W{1'b0}}, 1'b1} << n_use) - (ROW_W + 1)'(1);
  assign diag_ok   = ((cand_row & span_mask[ROW_W-1:0]) == '0);

  // Walk reads rows 0..n-1, one a cycle.
  assign issue  = cmd.walk_step && (COUNT_W'(walk_addr) < n_use);
  // Every row other than the candidate's must know the candidate.
  assign ok_now = ok && (!rd_pend || (rd_idx == candidate) ||
                         rd_data[IDX_W'(candidate)]);
  assign found_now = ok_now && diag_ok;

  assign sts.last_row = ((COUNT_W'(rows_loaded) + COUNT_W'(1)) == n_use);
  assign sts.walk_end = rd_pend && (COUNT_W'(walk_addr) == n_use);
  assign sts.out_free = !out_valid || out_ready;

  // Configuration register; a write also restarts the matrix.
  always_ff @(posedge clk) begin
    if (rst) begin
      people_count <= PEOPLE_RESET;
    end else if (cfg_write_en) begin
      people_count <= cfg_wdata;
    end
  end

  // Row counter and elimination candidate. The candidate's own row is kept
  // beside it, so elimination needs no memory read.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_loaded <= '0;
      candidate   <= '0;
    end else if (cfg_write_en) begin
      rows_loaded <= '0;
      candidate   <= '0;
    end else if (cmd.load) begin
      rows_loaded <= sts.last_row ? '0 : rows_loaded + CNT_W'(1);
      if (rows_loaded == '0) begin
        candidate <= '0;
      end else if (cand_row[IDX_W'(rows_loaded)]) begin
        candidate <= rows_loaded[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && ((rows_loaded == '0) || cand_row[IDX_W'(rows_loaded)])) begin
      cand_row <= row_bits;
    end
  end

  // Row memory: written while loading, read by the walk.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rows_mem[rows_loaded[ADDR_W-1:0]] <= row_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= rows_mem[walk_addr[ADDR_W-1:0]];
      rd_idx  <= walk_addr[ADDR_W-1:0];
    end
  end

  // Walk control and the running verdict.
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_addr <= '0;
      rd_pend   <= 1'b0;
      ok        <= 1'b1;
    end else if (cmd.walk_start) begin
      walk_addr <= '0;
      rd_pend   <= 1'b0;
      ok        <= 1'b1;
    end else begin
      rd_pend <= issue;
      ok      <= ok_now;
      if (issue) begin
        walk_addr <= walk_addr + CNT_W'(1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      found           <= found_now;
      celebrity_index <= found_now ? IDX_W'(candidate) : '0;
    end
  end

endmodule

// ----- design/universal_sink_finder.sv -----
// ----------------------------------------------------------------------------
// universal_sink_finder
// Finds the celebrity (universal sink) of a knows-matrix loaded row by row.
// ----------------------------------------------------------------------------
// Rows 0..n-1 of the matrix are taken one per cycle, row 0 first; bit j of a
// row means that person knows person j, and bits at or above n are ignored.
// An elimination candidate follows the rows as they arrive, using a copy of
// the candidate's row held in a register. Once the last row is in, the block
// stops taking rows and walks the row memory through its single read port,
// one row a cycle. The result is registered when the walk has checked the
// last row and the result register is free. Rows are refused during the walk,
// and for longer while an earlier result has still not been taken.
// One request then leaves: found, and the celebrity's index (zero when none).
// Writing people_count drops any partly loaded matrix; the user must write it
// only while the block is idle, and the block does not enforce this.
module universal_sink_finder #(
  parameter int MAX_PEOPLE = usf_pkg::DEF_MAX_PEOPLE
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [usf_pkg::COUNT_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [usf_pkg::ROW_W-1:0]   row_bits,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        found,
  output logic [usf_pkg::IDX_W-1:0]   celebrity_index
);
  import usf_pkg::*;

  usf_cmd_t cmd;
  usf_sts_t sts;

  // Sequencing of load, walk and result hand-over.
  usf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Row storage, candidate tracking and verification.
  usf_datapath #(
    .MAX_PEOPLE (MAX_PEOPLE)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_wdata       (cfg_wdata),
    .row_bits        (row_bits),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .found           (found),
    .celebrity_index (celebrity_index),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// ----- sim/tb_universal_sink_finder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_universal_sink_finder
// Self-checking bench for the universal sink finder. The bench sends knows
// matrices row by row. It keeps its own model of the elimination and the
// final check, and compares every result request with the verdict that the
// model predicts. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module tb_universal_sink_finder;
  import usf_pkg::*;

  localparam int PEOPLE_CAP    = (DEF_MAX_PEOPLE < ROW_W) ? DEF_MAX_PEOPLE : ROW_W;
  localparam int RANDOM_ROWS   = 1800;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = PEOPLE_CAP + 8;

  // Kinds of generated matrix.
  typedef enum int {
    MX_CELEB,   // a celebrity is planted
    MX_BROKEN,  // a planted celebrity with one condition broken
    MX_NOISE    // random rows
  } matrix_kind_t;

  // One expected result.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } verdict_t;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                cfg_write_en = 1'b0;
  logic [COUNT_W-1:0]  cfg_wdata    = '0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [ROW_W-1:0]    row_bits     = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic                found;
  logic [IDX_W-1:0]    celebrity_index;

  // Model state of the block.
  logic [ROW_W-1:0]    model_rows [PEOPLE_CAP];
  logic [COUNT_W-1:0]  model_count  = PEOPLE_RESET;
  int unsigned         model_loaded = 0;
  int unsigned         model_cand   = 0;

  verdict_t            verdict_q [$];
  int unsigned         error_count  = 0;
  int unsigned         rows_sent    = 0;
  bit                  no_gaps      = 1'b0;
  int unsigned         out_stall    = 0;

  universal_sink_finder dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .row_bits        (row_bits),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .found           (found),
    .celebrity_index (celebrity_index)
  );

  always #5 clk = ~clk;

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Matrix size in use for a register value: 0 acts as 1, the cap bounds it.
  function automatic int unsigned effective_people(input logic [COUNT_W-1:0] value);
    int unsigned n;
    n = value;
    if (n < 1) n = 1;
    if (n > PEOPLE_CAP) n = PEOPLE_CAP;
    return n;
  endfunction

  // Row with a random density of set bits.
  function automatic logic [ROW_W-1:0] random_row();
    case ($urandom_range(0, 2))
      0: return $urandom() & $urandom();
      1: return $urandom() | $urandom();
      default: return $urandom();
    endcase
  endfunction

  // Store one accepted row, follow the candidate and, on the last row,
  // predict the verdict of the final check.
  task automatic absorb_row(input logic [ROW_W-1:0] row);
    int unsigned n;
    int unsigned r;
    bit          ok;
    verdict_t    v;
    n = effective_people(model_count);
    r = model_loaded;
    if (r >= n) begin
      r = 0;
      model_cand = 0;
    end
    if (r == 0) begin
      model_cand = 0;
    end else if (model_rows[model_cand][r]) begin
      model_cand = r;
    end
    model_rows[r] = row;
    r++;
    model_loaded = r;
    if (r < n) return;
    ok = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (model_rows[model_cand][i]) ok = 1'b0;
      if (i != model_cand && !model_rows[i][model_cand]) ok = 1'b0;
    end
    v.found = ok;
    v.idx   = ok ? IDX_W'(model_cand) : '0;
    verdict_q.push_back(v);
    model_loaded = 0;
    model_cand   = 0;
  endtask

  // Send one row request after a random gap and record it once accepted.
  // Valid stays high when the next row follows with no gap.
  task automatic send_row(input logic [ROW_W-1:0] row);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    row_bits <= row;
    do @(posedge clk); while (!in_ready);
    absorb_row(row);
    rows_sent++;
  endtask

  // Stop sending and wait until every predicted result has come back and
  // the block has had time to finish any work in progress.
  task automatic settle();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the people count while the block is idle.
  task automatic set_people_count(input logic [COUNT_W-1:0] value);
    settle();
    cfg_write_en <= 1'b1;
    cfg_wdata    <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    model_count  = value;
    model_loaded = 0;
    model_cand   = 0;
  endtask

  // Build an n-person matrix of the given kind and send its first rows.
  task automatic send_matrix(input int unsigned n, input matrix_kind_t kind,
                             input int unsigned rows_to_send);
    logic [ROW_W-1:0] rows [PEOPLE_CAP];
    logic [ROW_W-1:0] low_mask;
    int unsigned      c;
    int unsigned      victim;
    low_mask = {ROW_W{1'b1}} >> (ROW_W - n);
    c = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) rows[i] = random_row();
    if (kind != MX_NOISE) begin
      for (int i = 0; i < n; i++) begin
        if (i == c) rows[i] = rows[i] & ~low_mask;
        else rows[i][c] = 1'b1;
      end
      if (kind == MX_BROKEN) begin
        if (n == 1 || $urandom_range(0, 1) == 1) begin
          rows[c][$urandom_range(0, n - 1)] = 1'b1;
        end else begin
          victim = $urandom_range(0, n - 2);
          if (victim >= c) victim++;
          rows[victim][c] = 1'b0;
        end
      end
    end
    for (int i = 0; i < rows_to_send; i++) send_row(rows[i]);
  endtask

  // The count after reset is the full size.
  task automatic test_reset_count();
    send_matrix(PEOPLE_CAP, MX_CELEB, PEOPLE_CAP);
  endtask

  // One person: only the diagonal bit matters.
  task automatic test_single_person();
    set_people_count(COUNT_W'(1));
    send_row(32'h0000_0000);
    send_row(32'h0000_0001);
    send_row(32'hFFFF_FFFE);
    send_row(32'hFFFF_FFFF);
  endtask

  // A count of zero behaves as one person.
  task automatic test_zero_count();
    set_people_count(COUNT_W'(0));
    send_row(32'hFFFF_FFFE);
    send_row(32'h0000_0001);
  endtask

  // Two people: each outcome, and bits above the matrix ignored.
  task automatic test_two_people();
    set_people_count(COUNT_W'(2));
    send_row(32'h0000_0002);
    send_row(32'h0000_0000);
    send_row(32'h0000_0000);
    send_row(32'h0000_0001);
    send_row(32'h0000_0000);
    send_row(32'h0000_0000);
    send_row(32'hFFFF_FFFC);
    send_row(32'hFFFF_FFFD);
    send_row(32'h0000_0003);
    send_row(32'h0000_0003);
  endtask

  // A register write drops the matrix being loaded.
  task automatic test_dropped_matrix();
    set_people_count(COUNT_W'(3));
    send_row(32'h0000_0004);
    send_row(32'h0000_0000);
    set_people_count(COUNT_W'(3));
    send_row(32'h0000_0004);
    send_row(32'h0000_0004);
    send_row(32'h8000_0000);
  endtask

  // Phases of random matrices at random sizes, mostly small.
  task automatic test_random_matrices();
    logic [COUNT_W-1:0] value;
    int unsigned        n;
    int unsigned        phase;
    int unsigned        roll;
    int unsigned        start;
    matrix_kind_t       kind;
    phase = 0;
    start = rows_sent;
    while (rows_sent < start + RANDOM_ROWS) begin
      roll = $urandom_range(0, 99);
      if (phase == 0) value = COUNT_W'(63);
      else if (phase == 1) value = COUNT_W'(33);
      else if (phase == 2) value = COUNT_W'(32);
      else if (roll < 70) value = COUNT_W'($urandom_range(1, 8));
      else if (roll < 85) value = COUNT_W'($urandom_range(9, 31));
      else if (roll < 93) value = COUNT_W'(32);
      else if (roll < 97) value = COUNT_W'(0);
      else value = COUNT_W'($urandom_range(33, 63));
      set_people_count(value);
      n = effective_people(value);
      no_gaps = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(2, 8)) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) kind = MX_CELEB;
        else if (roll < 80) kind = MX_BROKEN;
        else kind = MX_NOISE;
        send_matrix(n, kind, n);
      end
      // Now and then leave a partial matrix for the next write to drop.
      if (n >= 2 && $urandom_range(0, 9) == 0) begin
        send_matrix(n, MX_NOISE, $urandom_range(1, n - 1));
      end
      phase++;
    end
    no_gaps = 1'b0;
  endtask

  // Result side: random stalls, and each result request checked in order.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result with none expected, actual found %0b index %0d",
                   $time, found, celebrity_index);
          error_count++;
        end else begin
          if (found !== verdict_q[0].found) begin
            $display("%0t: found mismatch, expected %0b, actual %0b",
                     $time, verdict_q[0].found, found);
            error_count++;
          end
          if (celebrity_index !== verdict_q[0].idx) begin
            $display("%0t: celebrity_index mismatch, expected %0d, actual %0d",
                     $time, verdict_q[0].idx, celebrity_index);
            error_count++;
          end
          void'(verdict_q.pop_front());
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall = pick_gap();
      end
    end
  end

  // Watchdog: too long without any request or register write ends the run.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_write_en || (in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Test sequence.
  initial begin
    for (int i = 0; i < PEOPLE_CAP; i++) model_rows[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_count();
    test_single_person();
    test_zero_count();
    test_two_people();
    test_dropped_matrix();
    test_random_matrices();
    settle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
